// ----- hdl/tmm_pkg.sv -----
package tmm_pkg;

    localparam int IDX_W      = 3;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 32;
    localparam int PSUM_W     = 36;
    localparam int CFG_W      = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - PSUM_W - 2 * IDX_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INNER_COUNT  = 2'd2;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_COMPUTE
    } t_state;

    // MAC pipeline tag, travels alongside the operands
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             first;
        logic             last_k;
        logic             last_elem;
    } t_tag;

    typedef struct packed {
        logic                     last;
        logic signed [PSUM_W-1:0] sum;
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         row;
    } t_result;

endpackage

// ----- hdl/tmm_tile_store.sv -----
module tmm_tile_store #(
    parameter int AW = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic signed [tmm_pkg::ELEM_W-1:0]  i_wdata,
    input  logic                               i_re,
    input  logic [AW-1:0]                      i_raddr,
    output logic signed [tmm_pkg::ELEM_W-1:0]  o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic signed [tmm_pkg::ELEM_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]                  r_valid;
    logic signed [tmm_pkg::ELEM_W-1:0] r_rdata;
    logic                              r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ----- hdl/tmm_mac.sv -----
module tmm_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  tmm_pkg::t_tag                      i_tag,
    input  logic signed [tmm_pkg::ELEM_W-1:0]  i_a,
    input  logic signed [tmm_pkg::ELEM_W-1:0]  i_b,
    output logic                               o_res_valid,
    output tmm_pkg::t_result                   o_res
);

    tmm_pkg::t_tag                     r_tag;
    logic signed [tmm_pkg::PROD_W-1:0] r_prod;
    logic signed [tmm_pkg::PSUM_W-1:0] r_acc;
    logic signed [tmm_pkg::PSUM_W-1:0] n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_adv) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= i_a * i_b;
        end
        if (i_adv && r_tag.valid) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        n_acc = (r_tag.first ? '0 : r_acc) + tmm_pkg::PSUM_W'(r_prod);
    end

    assign o_res_valid = i_adv && r_tag.valid && r_tag.last_k;
    assign o_res.last  = r_tag.last_elem;
    assign o_res.sum   = n_acc;
    assign o_res.col   = r_tag.col;
    assign o_res.row   = r_tag.row;

endmodule

// ----- hdl/tiled_matrix_multiply_core.sv -----
// Tiled matrix multiply core: one tile of C = A x B, signed 16-bit elements.
// Input stream (s_axis): one transaction per command. cmd 0 loads an A element,
// cmd 1 a B element at (row, col); loads outside the configured sizes are
// dropped. cmd 2 computes C and emits rows*columns transactions on m_axis in
// row-major order, tlast on the final element; cmd 3 does nothing.
// Sizes come from the write port (row, column, inner count), clamped to
// 1..min(TILE,8); write them only while the core is idle.
// Loads are accepted back to back while the core is idle. A compute issues one
// multiply-accumulate per cycle from the tile memories while m_axis does not
// stall, and holds s_axis off until the last one has issued. It uses a single
// MAC and one read port per tile memory.
// When m_axis stalls, the output register holds and the read/MAC pipeline
// freezes until the transaction completes.
// Reset sets all sizes to 8 and marks every tile entry unwritten, so both tiles
// read as zero; no clearing pass is needed.
module tiled_matrix_multiply_core #(
    parameter int TILE = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tmm_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [tmm_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // cmd[1:0], row_index[4:2], col_index[7:5], element[23:8]
    input  logic [tmm_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // out_row[2:0], out_col[5:3], product_sum[41:6], zero[47:42]
    output logic [tmm_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);

    localparam int LIM = (TILE < 8) ? TILE : 8;
    localparam int IW  = $clog2(LIM);
    localparam int AW  = 2 * IW;

    function automatic logic [IW-1:0] f_last(input logic [tmm_pkg::CFG_W-1:0] v);
        logic [IW-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > tmm_pkg::CFG_W'(LIM)) begin
            res = IW'(LIM - 1);
        end else begin
            res = IW'(v - 1'b1);
        end
        return res;
    endfunction

    logic [tmm_pkg::CFG_W-1:0] r_row_count;
    logic [tmm_pkg::CFG_W-1:0] r_column_count;
    logic [tmm_pkg::CFG_W-1:0] r_inner_count;
    logic [IW-1:0]             last_row;
    logic [IW-1:0]             last_col;
    logic [IW-1:0]             last_inner;

    tmm_pkg::t_state r_state;
    tmm_pkg::t_state n_state;
    logic [IW-1:0]   r_i, r_j, r_k;
    logic [IW-1:0]   n_i, n_j, n_k;
    tmm_pkg::t_tag   r_t1;
    tmm_pkg::t_tag   n_t1;
    logic            issue;
    logic            issue_last;
    logic            adv;

    logic                               in_accept;
    logic [1:0]                         in_cmd;
    logic [tmm_pkg::IDX_W-1:0]          in_row;
    logic [tmm_pkg::IDX_W-1:0]          in_col;
    logic signed [tmm_pkg::ELEM_W-1:0]  in_elem;

    logic                               a_we, b_we;
    logic signed [tmm_pkg::ELEM_W-1:0]  a_rdata, b_rdata;

    logic             res_valid;
    tmm_pkg::t_result res;
    logic             r_out_valid;
    logic             n_out_valid;
    tmm_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= tmm_pkg::CFG_RESET;
            r_column_count <= tmm_pkg::CFG_RESET;
            r_inner_count  <= tmm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tmm_pkg::REG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                tmm_pkg::REG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                tmm_pkg::REG_INNER_COUNT:  r_inner_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign last_row   = f_last(r_row_count);
    assign last_col   = f_last(r_column_count);
    assign last_inner = f_last(r_inner_count);

    assign in_cmd    = i_s_axis_tdata[1:0];
    assign in_row    = i_s_axis_tdata[4:2];
    assign in_col    = i_s_axis_tdata[7:5];
    assign in_elem   = i_s_axis_tdata[23:8];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign a_we = in_accept && (in_cmd == tmm_pkg::CMD_LOAD_A)
               && (in_row <= tmm_pkg::IDX_W'(last_row))
               && (in_col <= tmm_pkg::IDX_W'(last_inner));
    assign b_we = in_accept && (in_cmd == tmm_pkg::CMD_LOAD_B)
               && (in_row <= tmm_pkg::IDX_W'(last_inner))
               && (in_col <= tmm_pkg::IDX_W'(last_col));

    assign adv        = !r_out_valid || i_m_axis_tready;
    assign issue_last = (r_k == last_inner) && (r_j == last_col) && (r_i == last_row);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tmm_pkg::ST_IDLE: begin
                if (in_accept && in_cmd == tmm_pkg::CMD_COMPUTE) begin
                    n_state = tmm_pkg::ST_COMPUTE;
                end
            end
            tmm_pkg::ST_COMPUTE: begin
                if (adv && issue_last) begin
                    n_state = tmm_pkg::ST_IDLE;
                end
            end
            default: n_state = tmm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            tmm_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                issue           = 1'b0;
            end
            tmm_pkg::ST_COMPUTE: begin
                o_s_axis_tready = 1'b0;
                issue           = 1'b1;
            end
            default: begin
                o_s_axis_tready = 1'b0;
                issue           = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        if (issue && adv) begin
            if (r_k == last_inner) begin
                n_k = '0;
                if (r_j == last_col) begin
                    n_j = '0;
                    n_i = (r_i == last_row) ? '0 : r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end else begin
                n_k = r_k + 1'b1;
            end
        end
    end

    always_comb begin
        n_t1.valid     = issue;
        n_t1.row       = tmm_pkg::IDX_W'(r_i);
        n_t1.col       = tmm_pkg::IDX_W'(r_j);
        n_t1.first     = (r_k == '0);
        n_t1.last_k    = (r_k == last_inner);
        n_t1.last_elem = issue_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmm_pkg::ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_t1    <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            if (adv) begin
                r_t1 <= n_t1;
            end
        end
    end

    // loads happen only when idle; the read ports are enabled whenever the pipeline advances
    tmm_tile_store #(.AW(AW)) u_a_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (a_we),
        .i_waddr ({in_row[IW-1:0], in_col[IW-1:0]}),
        .i_wdata (in_elem),
        .i_re    (adv),
        .i_raddr ({r_i, r_k}),
        .o_rdata (a_rdata)
    );

    tmm_tile_store #(.AW(AW)) u_b_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (b_we),
        .i_waddr ({in_row[IW-1:0], in_col[IW-1:0]}),
        .i_wdata (in_elem),
        .i_re    (adv),
        .i_raddr ({r_k, r_j}),
        .o_rdata (b_rdata)
    );

    tmm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_tag       (r_t1),
        .i_a         (a_rdata),
        .i_b         (b_rdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_out_valid = adv ? res_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {{tmm_pkg::OUT_PAD_W{1'b0}}, r_out.sum, r_out.col, r_out.row};

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_we || b_we) |-> (r_state == tmm_pkg::ST_IDLE))
        else $error("tile store written during compute");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |->
            (r_out.row == tmm_pkg::IDX_W'(last_row)) && (r_out.col == tmm_pkg::IDX_W'(last_col)))
        else $error("tlast away from final element");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> ($stable(r_k) && $stable(r_t1)))
        else $error("pipeline moved during output stall");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILE_DIM        = 8;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 58;

    localparam logic [1:0]                     CMD_NOP    = 2'd3;
    localparam logic [tmm_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic {
        STEP_REG_WRITE,
        STEP_COMMAND
    } t_step_kind;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall;

    typedef struct packed {
        t_step_kind                 kind;
        logic [1:0]                 code;     // command, or register index
        logic [tmm_pkg::IDX_W-1:0]  row;
        logic [tmm_pkg::IDX_W-1:0]  col;
        logic [tmm_pkg::ELEM_W-1:0] value;
        logic                       pinned;   // every C element of this compute has sum below
        logic [tmm_pkg::PSUM_W-1:0] sum;
    } t_step;

    t_step directed_steps [32] = '{
        // straight after reset both tiles read as zero
        '{STEP_COMMAND,   tmm_pkg::CMD_COMPUTE,      3'd0, 3'd0, 16'h0000, 1'b1, 36'h0},
        '{STEP_REG_WRITE, tmm_pkg::REG_ROW_COUNT,    3'd0, 3'd0, 16'd1,    1'b0, 36'h0},
        '{STEP_REG_WRITE, tmm_pkg::REG_COLUMN_COUNT, 3'd0, 3'd0, 16'd1,    1'b0, 36'h0},
        '{STEP_REG_WRITE, tmm_pkg::REG_INNER_COUNT,  3'd0, 3'd0, 16'd1,    1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_A,       3'd0, 3'd0, 16'h8000, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_B,       3'd0, 3'd0, 16'h8000, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_COMPUTE,      3'd0, 3'd0, 16'h0000, 1'b1, 36'h040000000},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_A,       3'd0, 3'd0, 16'h7fff, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_COMPUTE,      3'd0, 3'd0, 16'h0000, 1'b1, 36'hFC0008000},
        // out-of-range loads and the spare command leave the tiles alone
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_A,       3'd1, 3'd0, 16'd5,    1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_A,       3'd0, 3'd1, 16'd5,    1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_B,       3'd1, 3'd0, 16'd5,    1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_B,       3'd0, 3'd1, 16'd5,    1'b0, 36'h0},
        '{STEP_COMMAND,   CMD_NOP,                   3'd7, 3'd7, 16'hffff, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_COMPUTE,      3'd0, 3'd0, 16'h0000, 1'b1, 36'hFC0008000},
        // zero acts as one, oversize clamps to the tile, spare index ignored
        '{STEP_REG_WRITE, tmm_pkg::REG_ROW_COUNT,    3'd0, 3'd0, 16'd0,    1'b0, 36'h0},
        '{STEP_REG_WRITE, tmm_pkg::REG_COLUMN_COUNT, 3'd0, 3'd0, 16'd15,   1'b0, 36'h0},
        '{STEP_REG_WRITE, tmm_pkg::REG_INNER_COUNT,  3'd0, 3'd0, 16'd9,    1'b0, 36'h0},
        '{STEP_REG_WRITE, REG_UNUSED,                3'd0, 3'd0, 16'd5,    1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_A,       3'd0, 3'd7, 16'h7fff, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_B,       3'd7, 3'd7, 16'h7fff, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_A,       3'd1, 3'd0, 16'h1234, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_B,       3'd7, 3'd0, 16'h8000, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_A,       3'd0, 3'd0, 16'hffff, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_COMPUTE,      3'd0, 3'd0, 16'h0000, 1'b0, 36'h0},
        '{STEP_REG_WRITE, tmm_pkg::REG_ROW_COUNT,    3'd0, 3'd0, 16'd8,    1'b0, 36'h0},
        '{STEP_REG_WRITE, tmm_pkg::REG_COLUMN_COUNT, 3'd0, 3'd0, 16'd8,    1'b0, 36'h0},
        '{STEP_REG_WRITE, tmm_pkg::REG_INNER_COUNT,  3'd0, 3'd0, 16'd8,    1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_A,       3'd7, 3'd7, 16'h8000, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_B,       3'd7, 3'd0, 16'h8000, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_LOAD_B,       3'd7, 3'd7, 16'h7fff, 1'b0, 36'h0},
        '{STEP_COMMAND,   tmm_pkg::CMD_COMPUTE,      3'd0, 3'd0, 16'h0000, 1'b0, 36'h0}
    };

    logic                             i_clk           = 1'b0;
    logic                             i_rst_n         = 1'b0;
    logic                             i_cfg_we        = 1'b0;
    logic [tmm_pkg::CFG_ADDR_W-1:0]   i_cfg_addr      = '0;
    logic [tmm_pkg::CFG_W-1:0]        i_cfg_data      = '0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [tmm_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata  = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [tmm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic                             o_m_axis_tlast;

    // shadow of the tile stores and size registers
    logic signed [tmm_pkg::ELEM_W-1:0] a_tile_copy [TILE_DIM*TILE_DIM] = '{default: '0};
    logic signed [tmm_pkg::ELEM_W-1:0] b_tile_copy [TILE_DIM*TILE_DIM] = '{default: '0};
    logic [tmm_pkg::CFG_W-1:0] row_count_reg    = tmm_pkg::CFG_RESET;
    logic [tmm_pkg::CFG_W-1:0] column_count_reg = tmm_pkg::CFG_RESET;
    logic [tmm_pkg::CFG_W-1:0] inner_count_reg  = tmm_pkg::CFG_RESET;

    tmm_pkg::t_result c_due [$];
    tmm_pkg::t_result got_elem;
    tmm_pkg::t_result want_elem;

    int     errors      = 0;
    int     cycle_count = 0;
    int     burst_left  = 0;
    int     stall_left  = 0;
    t_stall stall_mode  = STALL_NONE;

    bit                         effective;
    int                         counted;
    int                         nr;
    int                         nc;
    int                         nk;
    logic [1:0]                 code;
    logic [tmm_pkg::IDX_W-1:0]  row;
    logic [tmm_pkg::IDX_W-1:0]  col;
    logic [tmm_pkg::ELEM_W-1:0] value;
    logic [tmm_pkg::ELEM_W-1:0] a_extreme;
    logic [tmm_pkg::ELEM_W-1:0] b_extreme;

    tiled_matrix_multiply_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int clamp_size(logic [tmm_pkg::CFG_W-1:0] reg_value);
        if (reg_value == 0) return 1;
        if (reg_value > TILE_DIM) return TILE_DIM;
        return int'(reg_value);
    endfunction

    function automatic logic [tmm_pkg::CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 4'd15;
            default: return tmm_pkg::CFG_W'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic string fmt_c(tmm_pkg::t_result e);
        return $sformatf("row %0d col %0d sum %0d last %0b", e.row, e.col, e.sum, e.last);
    endfunction

    task automatic write_register(input logic [tmm_pkg::CFG_ADDR_W-1:0] index,
                                  input logic [tmm_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (index)
            tmm_pkg::REG_ROW_COUNT:    row_count_reg    = data;
            tmm_pkg::REG_COLUMN_COUNT: column_count_reg = data;
            tmm_pkg::REG_INNER_COUNT:  inner_count_reg  = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every C element still owed, then let the pipeline run dry
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (c_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic issue_command(input logic [1:0] cmd_code,
                                 input logic [tmm_pkg::IDX_W-1:0] at_row,
                                 input logic [tmm_pkg::IDX_W-1:0] at_col,
                                 input logic [tmm_pkg::ELEM_W-1:0] elem_value,
                                 input logic pinned,
                                 input logic [tmm_pkg::PSUM_W-1:0] pinned_sum,
                                 output bit took_effect);
        int               gap;
        int               rows;
        int               cols;
        int               inner;
        longint           acc;
        tmm_pkg::t_result elem;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {elem_value, at_col, at_row, cmd_code};
        do @(posedge i_clk); while (!o_s_axis_tready);

        rows  = clamp_size(row_count_reg);
        cols  = clamp_size(column_count_reg);
        inner = clamp_size(inner_count_reg);
        took_effect = 1'b0;
        case (cmd_code)
            tmm_pkg::CMD_LOAD_A: begin
                if (at_row < rows && at_col < inner) begin
                    a_tile_copy[{at_row, at_col}] = elem_value;
                    took_effect = 1'b1;
                end
            end
            tmm_pkg::CMD_LOAD_B: begin
                if (at_row < inner && at_col < cols) begin
                    b_tile_copy[{at_row, at_col}] = elem_value;
                    took_effect = 1'b1;
                end
            end
            tmm_pkg::CMD_COMPUTE: begin
                took_effect = 1'b1;
                for (int i = 0; i < rows; i++) begin
                    for (int j = 0; j < cols; j++) begin
                        acc = 0;
                        for (int k = 0; k < inner; k++) begin
                            acc += longint'(a_tile_copy[i*TILE_DIM+k])
                                 * longint'(b_tile_copy[k*TILE_DIM+j]);
                        end
                        elem.row  = tmm_pkg::IDX_W'(i);
                        elem.col  = tmm_pkg::IDX_W'(j);
                        elem.sum  = pinned ? pinned_sum : acc[tmm_pkg::PSUM_W-1:0];
                        elem.last = (i == rows - 1 && j == cols - 1);
                        c_due.push_back(elem);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // result side: checking, stall pattern and run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL tiled_matrix_multiply_core");
            $finish;
        end else begin
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got_elem.row  = o_m_axis_tdata[tmm_pkg::IDX_W-1:0];
                got_elem.col  = o_m_axis_tdata[2*tmm_pkg::IDX_W-1:tmm_pkg::IDX_W];
                got_elem.sum  = o_m_axis_tdata[2*tmm_pkg::IDX_W +: tmm_pkg::PSUM_W];
                got_elem.last = o_m_axis_tlast;
                if (c_due.size() == 0) begin
                    errors++;
                    $display("%0t C transaction: expected none, actual %s",
                             $time, fmt_c(got_elem));
                end else begin
                    want_elem = c_due.pop_front();
                    if (got_elem !== want_elem
                        || o_m_axis_tdata[tmm_pkg::OUT_TDATA_W-1 -: tmm_pkg::OUT_PAD_W] !== '0)
                    begin
                        errors++;
                        $display("%0t C transaction: expected %s, actual %s pad %h",
                                 $time, fmt_c(want_elem), fmt_c(got_elem),
                                 o_m_axis_tdata[tmm_pkg::OUT_TDATA_W-1 -: tmm_pkg::OUT_PAD_W]);
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = t_stall'($urandom_range(0, 3));
                stall_left = $urandom_range(16, 96);
            end
            stall_left--;
            case (stall_mode)
                STALL_NONE:  i_m_axis_tready <= 1'b1;
                STALL_LIGHT: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                STALL_HEAVY: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:     i_m_axis_tready <= (cycle_count % 3 == 0);
            endcase
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[s]) begin
            if (directed_steps[s].kind == STEP_REG_WRITE) begin
                settle();
                write_register(directed_steps[s].code,
                               directed_steps[s].value[tmm_pkg::CFG_W-1:0]);
            end else begin
                issue_command(directed_steps[s].code, directed_steps[s].row,
                              directed_steps[s].col, directed_steps[s].value,
                              directed_steps[s].pinned, directed_steps[s].sum, effective);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == 0) begin
                write_register(tmm_pkg::REG_ROW_COUNT, 4'd8);
                write_register(tmm_pkg::REG_COLUMN_COUNT, 4'd8);
                write_register(tmm_pkg::REG_INNER_COUNT, 4'd8);
            end else begin
                write_register(tmm_pkg::REG_ROW_COUNT, pick_size());
                write_register(tmm_pkg::REG_COLUMN_COUNT, pick_size());
                write_register(tmm_pkg::REG_INNER_COUNT, pick_size());
            end
            nr = clamp_size(row_count_reg);
            nc = clamp_size(column_count_reg);
            nk = clamp_size(inner_count_reg);
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    // whole A row against whole B column at full scale
                    row       = tmm_pkg::IDX_W'($urandom_range(0, nr - 1));
                    col       = tmm_pkg::IDX_W'($urandom_range(0, nc - 1));
                    a_extreme = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                    b_extreme = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                    for (int k = 0; k < nk; k++) begin
                        issue_command(tmm_pkg::CMD_LOAD_A, row, tmm_pkg::IDX_W'(k),
                                      a_extreme, 1'b0, '0, effective);
                        issue_command(tmm_pkg::CMD_LOAD_B, tmm_pkg::IDX_W'(k), col,
                                      b_extreme, 1'b0, '0, effective);
                        counted += 2;
                    end
                end else begin
                    repeat ($urandom_range(1, 10)) begin
                        if ($urandom_range(0, 6) == 0) begin
                            code = 2'($urandom_range(0, 3));
                            row  = tmm_pkg::IDX_W'($urandom_range(0, 7));
                            col  = tmm_pkg::IDX_W'($urandom_range(0, 7));
                        end else if ($urandom_range(0, 1) == 0) begin
                            code = tmm_pkg::CMD_LOAD_A;
                            row  = tmm_pkg::IDX_W'($urandom_range(0, nr - 1));
                            col  = tmm_pkg::IDX_W'($urandom_range(0, nk - 1));
                        end else begin
                            code = tmm_pkg::CMD_LOAD_B;
                            row  = tmm_pkg::IDX_W'($urandom_range(0, nk - 1));
                            col  = tmm_pkg::IDX_W'($urandom_range(0, nc - 1));
                        end
                        case ($urandom_range(0, 7))
                            0: value = 16'h8000;
                            1: value = 16'h7fff;
                            default: value = tmm_pkg::ELEM_W'($urandom);
                        endcase
                        issue_command(code, row, col, value, 1'b0, '0, effective);
                        if (effective) counted++;
                    end
                end
                issue_command(tmm_pkg::CMD_COMPUTE, '0, '0, '0, 1'b0, '0, effective);
                counted++;
            end
        end

        settle();
        if (errors == 0) begin
            $display("PASS tiled_matrix_multiply_core");
        end else begin
            $display("FAIL tiled_matrix_multiply_core");
        end
        $finish;
    end

endmodule
